@@ hdl/lsa_pkg.sv @@
// ----------------------------------------------------------------------------
// lsa_pkg : shared types and constants for the LIFO stack allocator
// Transaction payloads, operation and status codes, controller states and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lsa_pkg;

  localparam int BUFFER_BYTES = 4096;
  localparam int HEADER_BYTES = 8;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int OFS_W        = 13;
  // alignment masks reach 2^15-1, so top + header + mask + size fits in 17 bits
  localparam int ARITH_W      = 17;

  typedef enum logic [2:0] {
    FUNC_ALLOC   = 3'd0,
    FUNC_FREE    = 3'd1,
    FUNC_MARK    = 3'd2,
    FUNC_TO_MARK = 3'd3,
    FUNC_RESET   = 3'd4
  } func_e_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_ZERO_SIZE = 3'd1,
    STS_NO_MEM    = 3'd2,
    STS_OUTSIDE   = 3'd3,
    STS_FREED     = 3'd4,
    STS_NOT_LIFO  = 3'd5,
    STS_NULL      = 3'd6,
    STS_MARKER    = 3'd7
  } status_e_t;

  typedef struct packed {
    logic [2:0]       func;
    logic [OFS_W-1:0] alloc_size;
    logic [3:0]       align_log2;
    logic [11:0]      block_offset;
    logic             block_is_null;
    logic [OFS_W-1:0] marker_offset;
  } in_t;

  typedef struct packed {
    status_e_t        status;
    logic [OFS_W-1:0] granted_offset;
    logic [OFS_W-1:0] used_bytes;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_ALLOC2,
    ST_FREE2
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;    // capture the accepted transaction
    logic calc_data;  // register the aligned data offset
    logic mem_rd;     // read the header of the block being freed
    logic commit;     // update the top and issue the result
    logic clr_step;   // clear one header entry
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] func;
    logic       free_ok;
    logic       clr_last;
    logic       out_free;
  } dp_sts_t;

endpackage

@@ hdl/lsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// lsa_ctrl : allocator sequencer
// Runs the post-reset clearing pass, then steps each transaction through EXEC
// (then ALLOC2 or FREE2 if needed) and commits it when the output is free.
// ----------------------------------------------------------------------------
module lsa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lsa_pkg::dp_sts_t   sts,
  output lsa_pkg::ctrl_cmd_t cmd
);
  import lsa_pkg::*;

  state_t state, state_next;
  logic   finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    finish     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts.func)
          FUNC_ALLOC: begin
            cmd.calc_data = 1'b1;
            state_next    = ST_ALLOC2;
          end
          FUNC_FREE: begin
            if (sts.free_ok) begin
              cmd.mem_rd = 1'b1;
              state_next = ST_FREE2;
            end else begin
              finish = 1'b1;
            end
          end
          default: finish = 1'b1;
        endcase
      end
      ST_ALLOC2, ST_FREE2: finish = 1'b1;
      default: state_next = ST_IDLE;
    endcase

    // commit once the output register can take the result; the next
    // transaction is taken in the same cycle
    if (finish && sts.out_free) begin
      cmd.commit = 1'b1;
      in_ready   = 1'b1;
      if (in_valid) begin
        cmd.load_in = 1'b1;
        state_next  = ST_EXEC;
      end else begin
        state_next  = ST_IDLE;
      end
    end
  end

endmodule

@@ hdl/lsa_dpath.sv @@
// ----------------------------------------------------------------------------
// lsa_dpath : allocator datapath
// Holds the transaction, top offset, capacity, header memory and the
// output register, and works out each result.
// ----------------------------------------------------------------------------
module lsa_dpath (
  input  logic                      clk,
  input  logic                      rst,
  input  lsa_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lsa_pkg::out_t             out_data,
  input  logic                      cfg_we,
  input  logic [lsa_pkg::OFS_W-1:0] cfg_wdata,
  input  lsa_pkg::ctrl_cmd_t        cmd,
  output lsa_pkg::dp_sts_t          sts
);
  import lsa_pkg::*;

  in_t                in_q;
  logic [OFS_W-1:0]   top;
  logic [OFS_W-1:0]   top_next;
  logic [OFS_W-1:0]   capacity;
  logic [OFS_W-1:0]   cap_eff;
  logic [ARITH_W-1:0] amask;
  logic [ARITH_W-1:0] data_calc;
  logic [ARITH_W-1:0] data_q;
  logic [ARITH_W-1:0] end_sum;
  logic               alloc_fit;
  status_e_t          free_sts;
  status_e_t          res_sts;
  logic [OFS_W-1:0]   res_granted;
  logic               alloc_wr;
  logic [ADDR_W-1:0]  clr_cnt;
  logic [OFS_W-1:0]   hdr_mem [BUFFER_BYTES];
  logic [OFS_W-1:0]   rd_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [OFS_W-1:0]   mem_wd;
  logic [ADDR_W-1:0]  mem_ra;

  assign cap_eff = (capacity > OFS_W'(BUFFER_BYTES)) ? OFS_W'(BUFFER_BYTES) : capacity;

  // alloc: aligned data offset registered in EXEC, end and fit in ALLOC2
  assign amask     = (ARITH_W'(1) << in_q.align_log2) - ARITH_W'(1);
  assign data_calc = (ARITH_W'(top) + ARITH_W'(HEADER_BYTES) + amask) & ~amask;
  assign end_sum   = data_q + ARITH_W'(in_q.alloc_size);
  assign alloc_fit = end_sum <= ARITH_W'(cap_eff);

  always_comb begin
    priority if (in_q.block_is_null) begin
      free_sts = STS_NULL;
    end else if (OFS_W'(in_q.block_offset) >= cap_eff) begin
      free_sts = STS_OUTSIDE;
    end else if (OFS_W'(in_q.block_offset) >= top) begin
      free_sts = STS_FREED;
    end else if (in_q.block_offset < 12'(HEADER_BYTES)) begin
      free_sts = STS_OUTSIDE;
    end else begin
      free_sts = STS_OK;
    end
  end

  always_comb begin
    res_sts     = STS_OK;
    res_granted = '0;
    top_next    = top;
    alloc_wr    = 1'b0;
    unique case (in_q.func)
      FUNC_ALLOC: begin
        if (in_q.alloc_size == '0) begin
          res_sts = STS_ZERO_SIZE;
        end else if (!alloc_fit) begin
          res_sts = STS_NO_MEM;
        end else begin
          res_granted = data_q[OFS_W-1:0];
          top_next    = end_sum[OFS_W-1:0];
          alloc_wr    = 1'b1;
        end
      end
      FUNC_FREE: begin
        if (free_sts != STS_OK) begin
          res_sts = free_sts;
        end else if (rd_q > top) begin
          res_sts = STS_NOT_LIFO;
        end else begin
          top_next = rd_q;
        end
      end
      FUNC_TO_MARK: begin
        if (in_q.marker_offset <= cap_eff) begin
          top_next = in_q.marker_offset;
        end else begin
          res_sts = STS_MARKER;
        end
      end
      FUNC_RESET: top_next = '0;
      default: ;
    endcase
  end

  // header memory: clearing pass or header write, one read port
  assign mem_we = cmd.clr_step || (cmd.commit && alloc_wr);
  assign mem_wa = cmd.clr_step ? clr_cnt
                               : data_q[ADDR_W-1:0] - ADDR_W'(HEADER_BYTES);
  assign mem_wd = cmd.clr_step ? '0 : top;
  assign mem_ra = in_q.block_offset[ADDR_W-1:0] - ADDR_W'(HEADER_BYTES);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hdr_mem[mem_wa] <= mem_wd;
    end
    if (cmd.mem_rd) begin
      rd_q <= hdr_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_q <= in_data;
    end
    if (cmd.calc_data) begin
      data_q <= data_calc;
    end
    if (cmd.commit) begin
      out_data.status         <= res_sts;
      out_data.granted_offset <= res_granted;
      out_data.used_bytes     <= top_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top       <= '0;
      capacity  <= OFS_W'(BUFFER_BYTES);
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        top <= top_next;
      end
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.func     = in_q.func;
  assign sts.free_ok  = (free_sts == STS_OK);
  assign sts.clr_last = &clr_cnt;
  assign sts.out_free = !out_valid || out_ready;

endmodule

@@ hdl/lifo_stack_allocator.sv @@
// ----------------------------------------------------------------------------
// lifo_stack_allocator : bump allocator with LIFO release
// Allocates aligned blocks behind an 8-byte header that saves the previous
// top, frees by rewinding to a block's saved top, does mark / rewind / reset.
// ----------------------------------------------------------------------------
// After reset the header memory is swept to zero, one entry a cycle, across
// all 4096 entries; in_ready stays low during the sweep, capacity writes are
// taken throughout. Mark, free-to-marker, reset, undefined codes and a free
// that fails its checks finish in EXEC; alloc and a free that passes its
// checks go on to ALLOC2 or FREE2: alloc registers the aligned data offset
// before the end/capacity compare, free waits for the registered read of the
// header memory. The result lands in an output register, and the next
// transaction is taken in the same cycle as the previous one commits, so a
// stalled output only holds the block once a second result is ready behind
// it. One transaction is in flight at a time.
// ----------------------------------------------------------------------------
module lifo_stack_allocator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  lsa_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lsa_pkg::out_t             out_data,
  input  logic                      cfg_we,
  input  logic [lsa_pkg::OFS_W-1:0] cfg_wdata
);
  import lsa_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // sequencer: clearing pass, execution steps, commit
  lsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // top offset, capacity, header memory and result register
  lsa_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef SYNTH
  // no transaction may be taken while the header memory is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_step |-> !in_ready)
    else $error("transaction accepted during clearing pass");

  // a result is only committed into a free output register
  a_commit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> sts.out_free)
    else $error("commit overwrote a pending result");

  // the top never passes the buffer size
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.used_bytes <= OFS_W'(BUFFER_BYTES)))
    else $error("used_bytes beyond buffer");

  // a granted offset only comes with a successful transaction
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != STS_OK) |-> (out_data.granted_offset == '0))
    else $error("granted offset on failed transaction");
`endif

endmodule

@@ tb/tb_lifo_stack_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_lifo_stack_allocator : self-checking bench for the LIFO stack allocator
// A short table of directed transactions is followed by constrained-by-hand
// random traffic over several capacity settings and idle patterns. Every
// result is checked field by field against the table's expectation or an
// in-bench model of the allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lifo_stack_allocator;
  import lsa_pkg::*;

  // codes with no defined operation; the block must treat them as a no-op
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  localparam int DIRECTED_ROWS = 25;
  localparam int N_PHASES      = 6;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 10;
  // covers the clearing sweep plus ~1000 transactions with worst-case gaps
  // and stalls, with a wide margin
  localparam int LIMIT_CYCLES  = 200000;

  typedef struct {
    in_t  item;
    bit   typed;  // expectation written into the table
    out_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_t              in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             cfg_we    = 1'b0;
  logic [OFS_W-1:0] cfg_wdata = '0;

  lifo_stack_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Allocator model state: capacity register, top of stack, the saved-top
  // value held in each header slot, and the data offsets of blocks still
  // below the top (used only to steer stimulus towards legal frees).
  // --------------------------------------------------------------------------
  logic [OFS_W-1:0] cap_setting = 13'd4096;  // register reset value
  int unsigned      stack_top;
  int unsigned      saved_tops [BUFFER_BYTES];
  int unsigned      live_blocks [$];

  out_t results_due [$];

  stim_row_t directed [DIRECTED_ROWS];

  int phase_items [N_PHASES] = '{190, 30, 190, 190, 190, 160};
  int phase_idle  [N_PHASES] = '{0, 48, 0, 18, 48, 0};
  int phase_stall [N_PHASES] = '{0, 0, 48, 18, 0, 48};

  int idle_pct;
  int stall_pct = 0;
  bit hold_req  = 1'b0;
  bit hold_off  = 1'b0;

  int cycles;
  int mismatches;
  int sent;
  int checked;
  int granted;
  int rewinds;
  int n_settings;
  int status_seen [8];

  // clock: 4 ns period
  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("run stopped: cycle limit reached with %0d results due",
               results_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(string what, int want, int got);
    if (mismatches < 50)
      $display("mismatch at cycle %0d: %s expected %0d got %0d", cycles, what, want, got);
    mismatches++;
  endtask

  function automatic int unsigned usable_bytes();
    return (cap_setting > BUFFER_BYTES) ? BUFFER_BYTES : cap_setting;
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: applies one transaction to the model state and returns the
  // result the block should give for it.
  // --------------------------------------------------------------------------
  function automatic out_t predict_allocator(in_t it);
    out_t        r;
    int unsigned cap, amask, data_ofs, end_ofs, prev;
    cap = usable_bytes();
    r   = '0;
    r.status = STS_OK;
    case (it.func)
      FUNC_ALLOC: begin
        if (it.alloc_size == 0) begin
          r.status = STS_ZERO_SIZE;
        end else begin
          // header sits immediately below the aligned data offset
          amask    = (32'd1 << it.align_log2) - 1;
          data_ofs = (stack_top + HEADER_BYTES + amask) & ~amask;
          end_ofs  = data_ofs + it.alloc_size;
          if (end_ofs > cap) begin
            r.status = STS_NO_MEM;
          end else begin
            saved_tops[(data_ofs - HEADER_BYTES) % BUFFER_BYTES] = stack_top;
            r.granted_offset = OFS_W'(data_ofs);
            stack_top        = end_ofs;
            live_blocks.push_back(data_ofs);
            granted++;
          end
        end
      end
      FUNC_FREE: begin
        // priority: null, past capacity, at/above top, no room for a header
        if (it.block_is_null) begin
          r.status = STS_NULL;
        end else if (it.block_offset >= cap) begin
          r.status = STS_OUTSIDE;
        end else if (it.block_offset >= stack_top) begin
          r.status = STS_FREED;
        end else if (it.block_offset < HEADER_BYTES) begin
          r.status = STS_OUTSIDE;
        end else begin
          // an unwritten header slot reads as zero and rewinds to the bottom
          prev = saved_tops[(it.block_offset - HEADER_BYTES) % BUFFER_BYTES];
          if (prev > stack_top) begin
            r.status = STS_NOT_LIFO;
          end else begin
            stack_top = prev;
            rewinds++;
          end
        end
      end
      FUNC_TO_MARK: begin
        if (it.marker_offset <= cap) stack_top = it.marker_offset;
        else r.status = STS_MARKER;
      end
      FUNC_RESET: stack_top = 0;  // header slots are kept
      default: ;                  // mark and spare codes change nothing
    endcase
    while (live_blocks.size() != 0 && live_blocks[$] >= stack_top)
      void'(live_blocks.pop_back());
    r.used_bytes = OFS_W'(stack_top);
    return r;
  endfunction

  function automatic in_t op_item(logic [2:0] f, int size, int alog, int blk, bit nul,
                                  int marker);
    in_t it;
    it.func          = f;
    it.alloc_size    = OFS_W'(size);
    it.align_log2    = 4'(alog);
    it.block_offset  = 12'(blk);
    it.block_is_null = nul;
    it.marker_offset = OFS_W'(marker);
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Random request source. Mostly well-formed traffic: allocs of modest size,
  // frees of the newest live block (sometimes an older one), markers at or
  // below the top, marks and resets. The remainder is spare codes and fully
  // random noise. All fields start from random bits so unused fields toggle too.
  // --------------------------------------------------------------------------
  function automatic in_t draw_request();
    in_t         it;
    logic [63:0] noise;
    int unsigned cap, pick, roll, idx;
    noise = {$urandom, $urandom};
    it    = noise[$bits(in_t)-1:0];
    cap   = usable_bytes();
    pick  = $urandom_range(99);
    roll  = $urandom_range(99);
    if (pick < 40) begin
      it.func = FUNC_ALLOC;
      if (roll < 4) it.alloc_size = '0;
      else if (roll < 12) it.alloc_size = OFS_W'($urandom_range(1, BUFFER_BYTES));
      else it.alloc_size = OFS_W'($urandom_range(1, 160));
      it.align_log2 = (roll % 10 == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 6));
    end else if (pick < 72) begin
      it.func          = FUNC_FREE;
      it.block_is_null = (roll >= 95);
      if (live_blocks.size() != 0 && roll < 85) begin
        idx = (roll < 70) ? live_blocks.size() - 1 : $urandom_range(0, live_blocks.size() - 1);
        it.block_offset = 12'(live_blocks[idx]);
      end
    end else if (pick < 80) begin
      it.func = FUNC_MARK;
    end else if (pick < 88) begin
      it.func = FUNC_TO_MARK;
      if (roll < 70) it.marker_offset = OFS_W'($urandom_range(0, stack_top));
      else if (roll < 85) it.marker_offset = OFS_W'($urandom_range(0, cap));
    end else if (pick < 92) begin
      it.func = FUNC_RESET;
    end else if (pick < 96) begin
      it.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: optional idle gap, then hold valid until the transaction is taken.
  // Within a step, valid is only lowered when a gap is inserted, so back-to-back
  // items keep it high with a single assignment per step.
  // --------------------------------------------------------------------------
  task automatic offer(in_t it, bit typed, out_t want);
    out_t pred;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    pred = predict_allocator(it);
    results_due.push_back(typed ? want : pred);
    sent++;
  endtask

  // capacity is only changed with nothing in flight
  task automatic set_capacity(logic [OFS_W-1:0] v);
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cap_setting  = v;
    n_settings++;
  endtask

  // receiver: random stalls, or held off entirely during the pressure window
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // pressure: a long receiver hold-off while the sender keeps offering, so the
  // output register and the in-flight slot fill and in_ready drops
  initial begin
    wait (hold_req);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // result checker: oldest expectation first
  always @(posedge clk) begin
    out_t due;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with nothing due, used_bytes", 0, int'(out_data.used_bytes));
      end else begin
        due = results_due.pop_front();
        if (out_data.status !== due.status)
          report_mismatch("status", due.status, out_data.status);
        if (out_data.granted_offset !== due.granted_offset)
          report_mismatch("granted_offset", due.granted_offset, out_data.granted_offset);
        if (out_data.used_bytes !== due.used_bytes)
          report_mismatch("used_bytes", due.used_bytes, out_data.used_bytes);
        checked++;
      end
      status_seen[out_data.status]++;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned cap_val;

    // Directed table, from reset: capacity 4096, top 0, headers clear.
    // Rows with a typed expectation are the ones readable straight off the
    // spec; the rest rely on the predictor.
    directed[0]  = '{op_item(FUNC_MARK, 0, 0, 0, 0, 0), 1'b1, '{STS_OK, 13'd0, 13'd0}};
    directed[1]  = '{op_item(FUNC_ALLOC, 0, 0, 0, 0, 0), 1'b1, '{STS_ZERO_SIZE, 13'd0, 13'd0}};
    directed[2]  = '{op_item(FUNC_FREE, 0, 0, 0, 1, 0), 1'b1, '{STS_NULL, 13'd0, 13'd0}};
    // highest offset, above the empty stack's top
    directed[3]  = '{op_item(FUNC_FREE, 0, 0, 4095, 0, 0), 1'b1, '{STS_FREED, 13'd0, 13'd0}};
    // eight bytes too many once the header is counted
    directed[4]  = '{op_item(FUNC_ALLOC, 4096, 0, 0, 0, 0), 1'b1, '{STS_NO_MEM, 13'd0, 13'd0}};
    // largest size and alignment field values
    directed[5]  = '{op_item(FUNC_ALLOC, 8191, 15, 0, 0, 0), 1'b1, '{STS_NO_MEM, 13'd0, 13'd0}};
    // exact fill of the buffer
    directed[6]  = '{op_item(FUNC_ALLOC, 4088, 0, 0, 0, 0), 1'b1, '{STS_OK, 13'd8, 13'd4096}};
    // below the header size: no room for a header
    directed[7]  = '{op_item(FUNC_FREE, 0, 0, 4, 0, 0), 1'b1, '{STS_OUTSIDE, 13'd0, 13'd4096}};
    directed[8]  = '{op_item(FUNC_TO_MARK, 0, 0, 0, 0, 4097), 1'b1, '{STS_MARKER, 13'd0, 13'd4096}};
    directed[9]  = '{op_item(FUNC_TO_MARK, 0, 0, 0, 0, 8191), 1'b1, '{STS_MARKER, 13'd0, 13'd4096}};
    directed[10] = '{op_item(FUNC_FREE, 0, 0, 8, 0, 0), 1'b1, '{STS_OK, 13'd0, 13'd0}};
    // page alignment pushes the data offset to the end of the buffer
    directed[11] = '{op_item(FUNC_ALLOC, 1, 12, 0, 0, 0), 1'b1, '{STS_NO_MEM, 13'd0, 13'd0}};
    directed[12] = '{op_item(FUNC_ALLOC, 13, 4, 0, 0, 0), 1'b0, '0};
    directed[13] = '{op_item(FUNC_ALLOC, 100, 3, 0, 0, 0), 1'b0, '0};
    directed[14] = '{op_item(FUNC_ALLOC, 1, 1, 0, 0, 0), 1'b0, '0};
    directed[15] = '{op_item(FUNC_MARK, 0, 0, 0, 0, 0), 1'b0, '0};
    directed[16] = '{op_item(FUNC_FREE, 0, 0, 148, 0, 0), 1'b0, '0};  // newest block
    directed[17] = '{op_item(FUNC_FREE, 0, 0, 16, 0, 0), 1'b0, '0};   // first block, rewinds to 0
    directed[18] = '{op_item(FUNC_FREE, 0, 0, 40, 0, 0), 1'b0, '0};   // now above top
    directed[19] = '{op_item(FUNC_TO_MARK, 0, 0, 0, 0, 4096), 1'b0, '0};
    // header slot never written: rewinds to the bottom
    directed[20] = '{op_item(FUNC_FREE, 0, 0, 2000, 0, 0), 1'b0, '0};
    directed[21] = '{op_item(FUNC_TO_MARK, 0, 0, 0, 0, 100), 1'b0, '0};
    directed[22] = '{op_item(FUNC_SPARE_LO, 8191, 15, 4095, 1, 8191), 1'b0, '0};
    directed[23] = '{op_item(FUNC_SPARE_HI, 0, 0, 0, 0, 0), 1'b0, '0};
    directed[24] = '{op_item(FUNC_RESET, 8191, 15, 4095, 1, 8191), 1'b0, '0};

    idle_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // in_ready stays low through the header clearing sweep; the first
    // handshake simply waits it out
    foreach (directed[i]) offer(directed[i].item, directed[i].typed, directed[i].want);
    in_valid <= 1'b0;

    // Random phases. Capacities: beyond the buffer (clamped), zero, small,
    // random, full, random.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       cap_val = 8191;
        1:       cap_val = 0;
        2:       cap_val = 300;
        4:       cap_val = BUFFER_BYTES;
        default: cap_val = $urandom_range(64, BUFFER_BYTES);
      endcase
      set_capacity(OFS_W'(cap_val));
      idle_pct   = phase_idle[ph];
      stall_pct <= phase_stall[ph];
      if (ph == 0) hold_req = 1'b1;
      repeat (phase_items[ph]) offer(draw_request(), 1'b0, '0);
      in_valid <= 1'b0;
    end

    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d transactions (%0d directed) over %0d capacity writes: %0d checked, %0d blocks granted, %0d frees rewound",
             sent, DIRECTED_ROWS, n_settings, checked, granted, rewinds);
    $display("status mix: ok %0d zero-size %0d no-mem %0d outside %0d freed %0d null %0d marker %0d",
             status_seen[STS_OK], status_seen[STS_ZERO_SIZE], status_seen[STS_NO_MEM],
             status_seen[STS_OUTSIDE], status_seen[STS_FREED], status_seen[STS_NULL],
             status_seen[STS_MARKER]);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
